// ===== src/tcrs_pkg.sv =====
// Shared types and constants for the TFTP client receive sequencer.
// Used by the front classifier, the command queue, the back end and the top level.
// No dependencies.
package tcrs_pkg;

    // Input item kinds.
    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_PACKET = 2'd1;
    localparam logic [1:0] KIND_POLL   = 2'd2;

    // TFTP opcodes that the sequencer acts on.
    localparam logic [15:0] OP_DATA  = 16'd3;
    localparam logic [15:0] OP_ERROR = 16'd5;
    localparam logic [15:0] OP_OACK  = 16'd6;

    // Header bytes in front of the data, shortest useful data and request pacing.
    localparam int unsigned HDR_BYTES  = 12;
    localparam int unsigned MIN_DATA   = 4;
    localparam int unsigned REQ_PERIOD = 3;

    localparam int unsigned DEF_BLOCK_BYTES = 512;
    localparam int unsigned DEF_QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_REQ  = 2'd1,
        PH_OACK = 2'd2,
        PH_DATA = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_RUN   = 2'd0,
        ST_RETRY = 2'd1,
        ST_OK    = 2'd2,
        ST_FAIL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SEND_NONE = 2'd0,
        SEND_RRQ  = 2'd1,
        SEND_ACK  = 2'd2
    } send_t;

    // Item classes produced by the front end.
    typedef enum logic [2:0] {
        CLS_NOP   = 3'd0,
        CLS_START = 3'd1,
        CLS_VISIT = 3'd2,
        CLS_OACK  = 3'd3,
        CLS_DATA  = 3'd4,
        CLS_ERROR = 3'd5
    } cls_t;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        cls_t        cls;
        logic [15:0] blk;
        logic        blk_zero;
        logic        blk_one;
        logic [15:0] sidx;
        logic [15:0] dlen;
        logic        short_blk;
        logic [15:0] sport;
    } cmd_t;

    typedef struct packed {
        send_t       send_kind;
        logic [15:0] ack_block;
        logic        store_valid;
        logic [15:0] store_index;
        logic [15:0] store_length;
        logic [15:0] wrap_count;
        logic [15:0] remote_port;
        status_t     status;
        logic        timer_restart;
    } result_t;

endpackage

// ===== src/tcrs_front.sv =====
// Front end: decodes one input transaction into a classified command.
// Depends on tcrs_pkg.
module tcrs_front
    import tcrs_pkg::*;
#(
    parameter int unsigned BLOCK_BYTES = DEF_BLOCK_BYTES
)
(
    input  logic [1:0]  kind,
    input  logic [15:0] packet_opcode,
    input  logic [15:0] packet_block,
    input  logic [15:0] udp_length,
    input  logic [15:0] source_port,
    output cmd_t        cmd
);

    localparam logic [15:0] BLOCK_LEN = 16'(BLOCK_BYTES);
    localparam logic [15:0] HDR_LEN   = 16'(HDR_BYTES);
    localparam logic [15:0] MIN_LEN   = 16'(HDR_BYTES + MIN_DATA);

    logic [15:0] dlen;
    logic        data_ok;

    assign dlen    = udp_length - HDR_LEN;
    assign data_ok = (udp_length >= MIN_LEN);

    always_comb
    begin
        cmd.blk       = packet_block;
        cmd.blk_zero  = (packet_block == 16'd0);
        cmd.blk_one   = (packet_block == 16'd1);
        cmd.sidx      = packet_block - 16'd1;
        cmd.dlen      = dlen;
        cmd.short_blk = (dlen < BLOCK_LEN);
        cmd.sport     = source_port;
        case (kind)
            KIND_START:  cmd.cls = CLS_START;
            KIND_PACKET:
            begin
                if (packet_opcode == OP_OACK)
                    cmd.cls = CLS_OACK;
                else if (packet_opcode == OP_DATA && data_ok)
                    cmd.cls = CLS_DATA;
                else if (packet_opcode == OP_ERROR)
                    cmd.cls = CLS_ERROR;
                else
                    // Short data and opcodes without an action only count as a visit.
                    cmd.cls = CLS_VISIT;
            end
            KIND_POLL:   cmd.cls = CLS_VISIT;
            default:     cmd.cls = CLS_NOP;
        endcase
    end

endmodule

// ===== src/tcrs_queue.sv =====
// Small command queue that decouples the front end from the back end.
// Depends on tcrs_pkg.
module tcrs_queue
    import tcrs_pkg::*;
#(
    parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t head_cmd
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("command queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("command queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("command queue count beyond its depth");

endmodule

// ===== src/tcrs_back.sv =====
// Back end: applies classified commands to the transfer state and registers one result each.
// Holds the no_retry configuration bit. Depends on tcrs_pkg.
module tcrs_back
    import tcrs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cfg_we,
    input  logic    cfg_wdata,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    localparam logic [1:0] POLL_LAST = 2'(REQ_PERIOD - 1);

    phase_t      phase_reg, phase_next, phase_mid;
    logic [15:0] cur_reg, cur_next;
    logic [15:0] last_reg, last_next;
    logic [15:0] wraps_reg, wraps_next;
    logic [1:0]  poll_reg, poll_next;
    logic [15:0] port_reg, port_next;
    status_t     status_reg, status_next;
    logic        no_retry_reg;
    logic        out_valid_reg;
    result_t     result_reg, result_next;

    logic active, visit, first, store, done, restart;

    assign cmd_pop    = cmd_valid && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;
    assign active     = (phase_reg != PH_IDLE);

    // Next state of the transfer.
    always_comb
    begin
        phase_mid   = phase_reg;
        cur_next    = cur_reg;
        last_next   = last_reg;
        wraps_next  = wraps_reg;
        poll_next   = poll_reg;
        port_next   = port_reg;
        status_next = status_reg;
        first       = (phase_reg == PH_REQ) || (phase_reg == PH_OACK);
        store       = 1'b0;
        done        = 1'b0;
        restart     = 1'b0;
        visit       = 1'b0;
        if (cmd_pop)
        begin
            case (cmd.cls)
                CLS_START:
                begin
                    phase_mid   = PH_REQ;
                    cur_next    = '0;
                    wraps_next  = '0;
                    status_next = ST_RUN;
                end
                CLS_OACK:
                begin
                    if (active)
                    begin
                        phase_mid = PH_OACK;
                        port_next = cmd.sport;
                        restart   = 1'b1;
                    end
                end
                CLS_DATA:
                begin
                    if (active)
                    begin
                        restart  = 1'b1;
                        cur_next = cmd.blk;
                        if (first)
                        begin
                            // The first data block opens the data phase and fixes the server port.
                            phase_mid  = PH_DATA;
                            port_next  = cmd.sport;
                            last_next  = '0;
                            wraps_next = '0;
                            store      = cmd.blk_one;
                        end
                        else
                        begin
                            store = (cmd.blk != last_reg);
                            if (cmd.blk_zero && wraps_reg != 16'hFFFF)
                                wraps_next = wraps_reg + 16'd1;
                        end
                        if (store)
                        begin
                            last_next = cmd.blk;
                            if (cmd.short_blk)
                            begin
                                status_next = ST_OK;
                                done        = 1'b1;
                            end
                        end
                    end
                end
                CLS_ERROR:
                begin
                    if (active)
                    begin
                        phase_mid   = PH_IDLE;
                        status_next = no_retry_reg ? ST_FAIL : ST_RETRY;
                        restart     = !no_retry_reg;
                    end
                end
                default:
                begin
                end
            endcase
            visit = active && (cmd.cls != CLS_START) && (cmd.cls != CLS_NOP);
            if (visit && phase_mid == PH_REQ)
                poll_next = (poll_reg == POLL_LAST) ? 2'd0 : poll_reg + 2'd1;
        end
        phase_next = done ? PH_IDLE : phase_mid;
    end

    // Result of the command.
    always_comb
    begin
        result_next               = result_reg;
        if (cmd_pop)
        begin
            result_next.send_kind     = SEND_NONE;
            result_next.ack_block     = '0;
            result_next.store_valid   = store;
            result_next.store_index   = store ? cmd.sidx : 16'd0;
            result_next.store_length  = store ? cmd.dlen : 16'd0;
            result_next.wrap_count    = wraps_next;
            result_next.remote_port   = port_next;
            result_next.status        = status_next;
            result_next.timer_restart = restart;
            if (visit && phase_mid == PH_REQ && poll_reg == 2'd0)
                result_next.send_kind = SEND_RRQ;
            else if (visit && (phase_mid == PH_DATA || phase_mid == PH_OACK))
            begin
                result_next.send_kind = SEND_ACK;
                result_next.ack_block = cur_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            cur_reg       <= '0;
            last_reg      <= '0;
            wraps_reg     <= '0;
            poll_reg      <= '0;
            port_reg      <= '0;
            status_reg    <= ST_RUN;
            no_retry_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            cur_reg    <= cur_next;
            last_reg   <= last_next;
            wraps_reg  <= wraps_next;
            poll_reg   <= poll_next;
            port_reg   <= port_next;
            status_reg <= status_next;
            if (cfg_we)
                no_retry_reg <= cfg_wdata;
            if (cmd_pop)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    a_store_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.store_valid) |-> result_reg.timer_restart)
        else $error("stored block without timer restart");

    a_store_min_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.store_valid) |->
            (result_reg.store_length >= 16'(MIN_DATA)))
        else $error("stored block shorter than minimum data");

    a_ack_not_req: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && result_next.send_kind == SEND_ACK) |=> (phase_reg != PH_REQ))
        else $error("ack sent while staying in request phase");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && done) |=> (phase_reg == PH_IDLE && status_reg == ST_OK))
        else $error("completed transfer did not return to idle");

endmodule

// ===== src/tftp_client_receive_sequencer_core.sv =====
// Top level of the TFTP client receive sequencer.
// Instantiates tcrs_front, tcrs_queue and tcrs_back; depends on tcrs_pkg.
//
// Usage:
// The slave stream carries one transaction per event seen by the client: a start
// command, the header of a received packet, or a poll. s_tuser holds the kind and
// s_tdata the packet header fields. For every accepted input transaction the
// master stream delivers exactly one result transaction: m_tuser names the packet
// to transmit now (none, read request or ack) and m_tdata carries the ack block,
// the store command for the packet data, the wrap count, the server port, the
// transfer status and the timer restart flag.
// The front end classifies each input in the cycle it is accepted and writes the
// command into a short queue. From the queue the back end takes the command,
// updates the transfer state and loads the result register, from which the master
// side takes the result.
// One item per cycle is sustained unless the receiver stalls; then the result
// register holds and the back end stops, and the queue keeps accepting input until
// it is full, then s_tready drops. The user writes no_retry through cfg_we/cfg_wdata
// only while the block is idle; the block does not enforce this. Reset clears the
// queue, the result valid flag, the transfer state and no_retry.
module tftp_client_receive_sequencer_core
    import tcrs_pkg::*;
#(
    parameter int unsigned BLOCK_BYTES = DEF_BLOCK_BYTES,
    parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: bit 0 is no_retry.
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // packet_opcode, packet_block, udp_length, source_port
    input  logic [1:0]  s_tuser,  // kind
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // ack_block, store_valid, store_index, store_length, wrap_count, remote_port,
    // status, timer_restart, then four zero bits
    output logic [87:0] m_tdata,
    output logic [1:0]  m_tuser   // send_kind
);

    cmd_t    front_cmd;
    cmd_t    head_cmd;
    result_t result;
    logic    queue_full;
    logic    queue_not_empty;
    logic    queue_pop;
    logic    push;

    assign s_tready = !queue_full;
    assign push     = s_tvalid && s_tready;

    // Decode the incoming transaction into a command.
    tcrs_front #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_front (
        .kind          (s_tuser),
        .packet_opcode (s_tdata[15:0]),
        .packet_block  (s_tdata[31:16]),
        .udp_length    (s_tdata[47:32]),
        .source_port   (s_tdata[63:48]),
        .cmd           (front_cmd)
    );

    // Commands wait here while the result side is stalled.
    tcrs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (front_cmd),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .head_cmd  (head_cmd)
    );

    // Transfer state and the result register.
    tcrs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cmd_valid  (queue_not_empty),
        .cmd        (head_cmd),
        .cmd_pop    (queue_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tuser = result.send_kind;
    assign m_tdata = {4'b0000,
                      result.timer_restart,
                      result.status,
                      result.remote_port,
                      result.wrap_count,
                      result.store_length,
                      result.store_index,
                      result.store_valid,
                      result.ack_block};

endmodule
